/* rtl/typed_operand_stack_defines.svh */
// assertion macros used by the stack rtl
`ifndef TYPED_OPERAND_STACK_DEFINES_SVH
`define TYPED_OPERAND_STACK_DEFINES_SVH

// same-cycle implication, checked on every clock once out of reset
`define TOS_ASSERT_SAME(label, clock, reset, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
    else $error("stack check failed");

// next-cycle implication
`define TOS_ASSERT_NEXT(label, clock, reset, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
    else $error("stack check failed");

`endif

/* rtl/tos_pkg.sv */
`default_nettype none
package tos_pkg;

  // operation codes
  localparam logic [3:0] FN_PUSH    = 4'd0;
  localparam logic [3:0] FN_POP     = 4'd1;
  localparam logic [3:0] FN_DROP    = 4'd2;
  localparam logic [3:0] FN_TOP     = 4'd3;
  localparam logic [3:0] FN_PEEK    = 4'd4;
  localparam logic [3:0] FN_DUP     = 4'd5;
  localparam logic [3:0] FN_SWAP    = 4'd11;
  localparam logic [3:0] FN_RESET   = 4'd12;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNDER    = 2'd1;
  localparam logic [1:0] ST_OVER     = 2'd2;
  localparam logic [1:0] ST_BAD_OFFS = 2'd3;

  localparam int SLOT_W = 64;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // entries consumed by each dup-family op
  function automatic logic [2:0] dup_take(input logic [2:0] k);
    case (k)
      3'd0: return 3'd1;
      3'd1: return 3'd2;
      3'd2: return 3'd3;
      3'd3: return 3'd2;
      3'd4: return 3'd3;
      3'd5: return 3'd4;
      default: return 3'd2;
    endcase
  endfunction

  // entries written back by each dup-family op
  function automatic logic [2:0] dup_len(input logic [2:0] k);
    case (k)
      3'd0: return 3'd2;
      3'd1: return 3'd3;
      3'd2: return 3'd4;
      3'd3: return 3'd4;
      3'd4: return 3'd5;
      3'd5: return 3'd6;
      default: return 3'd2;
    endcase
  endfunction

  // source of write-back step i, 0 is the old top
  function automatic logic [1:0] dup_seq(input logic [2:0] k, input logic [2:0] i);
    logic [11:0] row;
    case (k)
      3'd1: row = 12'h004;
      3'd2: row = 12'h018;
      3'd3: row = 12'h011;
      3'd4: row = 12'h061;
      3'd5: row = 12'h1B1;
      3'd6: row = 12'h004;
      default: row = 12'h000;
    endcase
    return row[{i, 1'b0} +: 2];
  endfunction

endpackage
`default_nettype wire

/* rtl/tos_store.sv */
`default_nettype none
module tos_store import tos_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int TAG_WIDTH   = 3,
  parameter int AW          = 8
) (
  input  wire                  clk,
  input  wire                  we,
  input  wire [AW-1:0]         waddr,
  input  wire [SLOT_W-1:0]     wvalue,
  input  wire [TAG_WIDTH-1:0]  wtag,
  input  wire [AW-1:0]         raddr,
  output logic [SLOT_W-1:0]    rvalue,
  output logic [TAG_WIDTH-1:0] rtag
);

  logic [SLOT_W-1:0]    slot_mem [STACK_DEPTH];
  logic [TAG_WIDTH-1:0] tag_mem  [STACK_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wvalue;
      tag_mem[waddr]  <= wtag;
    end
    rvalue <= slot_mem[raddr];
    rtag   <= tag_mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/typed_operand_stack.sv */
`default_nettype none
// Typed operand stack. Issue an operation by raising start while busy is low;
// exactly one result follows, valid for the single cycle in which done is high,
// and it must be taken then since there is no way to hold it. An accepted
// operation reads the entries it consumes, writes its results back, then
// reports in the done state; the slot memory read is registered. Errors, drop,
// reset and unused codes go straight to done, push only writes, pop/top/peek
// only read, and the dup family does up to four reads and six writes
// (dup2_x2), all through the single read and single write port of the slot
// memory, one access each per cycle.
module typed_operand_stack import tos_pkg::*; #(
  parameter int STACK_DEPTH = 256,
  parameter int TAG_WIDTH   = 3
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [3:0]                            func,
  input  wire  [SLOT_W-1:0]                     push_value,
  input  wire  [TAG_WIDTH-1:0]                  push_tag,
  input  wire  [$clog2(STACK_DEPTH+1)-1:0]      amount,
  output logic                                  done,
  output logic [SLOT_W-1:0]                     read_value,
  output logic [TAG_WIDTH-1:0]                  read_tag,
  output logic [$clog2(STACK_DEPTH+1)-1:0]      depth,
  output logic [$clog2(STACK_DEPTH+1)-1:0]      peak_depth,
  output logic [1:0]                            status
);

`include "typed_operand_stack_defines.svh"

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [DW:0] DEPTH_MAX = (DW+1)'(STACK_DEPTH);

  state_t               state;
  logic [3:0]           op_func;
  logic [SLOT_W-1:0]    op_value;
  logic [TAG_WIDTH-1:0] op_tag;
  logic [DW-1:0]        op_offs;
  logic [DW-1:0]        base;
  logic [2:0]           take, len, ridx, widx;
  logic                 op_read;
  logic [SLOT_W-1:0]    v [4];
  logic [TAG_WIDTH-1:0] t [4];

  logic [SLOT_W-1:0]    mem_rvalue;
  logic [TAG_WIDTH-1:0] mem_rtag;
  logic [DW-1:0]        raddr_full;
  logic [DW-1:0]        waddr_full;
  logic [1:0]           wsrc;
  logic                 mem_we;

  // decode of the incoming operation
  logic [1:0] chk_status;
  logic [2:0] chk_take, chk_len;
  logic [2:0] dk;
  logic       is_dup;

  always_comb begin
    dk       = 3'(func - FN_DUP);
    is_dup   = (func >= FN_DUP) && (func <= FN_SWAP);
    chk_take = 3'd0;
    chk_len  = 3'd0;
    chk_status = ST_OK;
    case (func)
      FN_PUSH: begin
        chk_len = 3'd1;
        if ({1'b0, depth} >= DEPTH_MAX) chk_status = ST_OVER;
      end
      FN_POP, FN_TOP: begin
        chk_take = 3'd1;
        if (depth == '0) chk_status = ST_UNDER;
      end
      FN_DROP: begin
        if (amount > depth) chk_status = ST_UNDER;
      end
      FN_PEEK: begin
        chk_take = 3'd1;
        if (amount >= depth) chk_status = ST_BAD_OFFS;
      end
      default: begin
        if (is_dup) begin
          chk_take = dup_take(dk);
          chk_len  = dup_len(dk);
          if ({1'b0, depth} < (DW+1)'(chk_take)) chk_status = ST_UNDER;
          else if ({1'b0, depth} - (DW+1)'(chk_take) + (DW+1)'(chk_len) > DEPTH_MAX)
            chk_status = ST_OVER;
        end
      end
    endcase
  end

  // memory addressing
  assign raddr_full = depth - DW'(1) - op_offs - DW'(ridx);
  assign waddr_full = base + DW'(widx);
  assign wsrc       = dup_seq(3'(op_func - FN_DUP), widx);
  assign mem_we     = (state == S_WRITE);

  tos_store #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_WIDTH  (TAG_WIDTH),
    .AW         (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr_full[AW-1:0]),
    .wvalue((op_func == FN_PUSH) ? op_value : v[wsrc]),
    .wtag  ((op_func == FN_PUSH) ? op_tag : t[wsrc]),
    .raddr (raddr_full[AW-1:0]),
    .rvalue(mem_rvalue),
    .rtag  (mem_rtag)
  );

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // sequencer: accept, read consumed entries, write back, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= '0;
      peak_depth <= '0;
      status     <= ST_OK;
      read_value <= '0;
      read_tag   <= '0;
      ridx       <= '0;
      widx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op_func    <= func;
            op_value   <= push_value;
            op_tag     <= push_tag;
            op_offs    <= (func == FN_PEEK) ? amount : '0;
            op_read    <= (func == FN_POP) || (func == FN_TOP) || (func == FN_PEEK);
            take       <= chk_take;
            len        <= chk_len;
            base       <= depth - DW'(chk_take);
            ridx       <= '0;
            widx       <= '0;
            status     <= chk_status;
            read_value <= '0;
            read_tag   <= '0;
            if (chk_status != ST_OK) begin
              state <= S_DONE;
            end else if (chk_take != 3'd0) begin
              state <= S_READ;
            end else if (chk_len != 3'd0) begin
              state <= S_WRITE;
            end else begin
              if (func == FN_DROP) depth <= depth - amount;
              if (func == FN_RESET) depth <= '0;
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          // data of the address issued last cycle
          if (ridx != 3'd0) begin
            v[2'(ridx - 3'd1)] <= mem_rvalue;
            t[2'(ridx - 3'd1)] <= mem_rtag;
          end
          if (ridx == take) begin
            if (op_read) begin
              read_value <= mem_rvalue;
              read_tag   <= mem_rtag;
              if (op_func == FN_POP) depth <= depth - DW'(1);
              state <= S_DONE;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            ridx <= ridx + 3'd1;
          end
        end
        S_WRITE: begin
          if (widx == len - 3'd1) begin
            depth <= base + DW'(len);
            if (base + DW'(len) > peak_depth) peak_depth <= base + DW'(len);
            state <= S_DONE;
          end else begin
            widx <= widx + 3'd1;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer
  `TOS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TOS_ASSERT_SAME(a_err_zero, clk, rst, done && (status != ST_OK),
                   (read_value == '0) && (read_tag == '0))
  `TOS_ASSERT_SAME(a_peak_ge, clk, rst, 1'b1, peak_depth >= depth)
  `TOS_ASSERT_SAME(a_depth_max, clk, rst, 1'b1, {1'b0, depth} <= DEPTH_MAX)
  `TOS_ASSERT_NEXT(a_done_once, clk, rst, done, !done)

endmodule
`default_nettype wire
